/* rtl/bvi_pkg.sv */
// shared types and constants for the wrapped interval add/sub/add-multiply block
`timescale 1ns / 1ps
package bvi_pkg;

    localparam int DATA_W        = 64;
    localparam int WIDTH_W       = 7;
    localparam int OP_W          = 3;
    localparam int MAX_WIDTH_DEF = 64;
    localparam int EXT_W         = DATA_W + 1;      // operand with sign extension
    localparam int PROD_W        = 2 * EXT_W + 1;   // exact a + b*c

    typedef enum logic [OP_W-1:0] {
        OP_ADD_U    = 3'd0,
        OP_ADD_S    = 3'd1,
        OP_SUB_U    = 3'd2,
        OP_SUB_S    = 3'd3,
        OP_ADDMUL_U = 3'd4,
        OP_ADDMUL_S = 3'd5
    } t_op;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [WIDTH_W-1:0] width;
        logic [DATA_W-1:0]  a_low;
        logic [DATA_W-1:0]  a_high;
        logic [DATA_W-1:0]  b_low;
        logic [DATA_W-1:0]  b_high;
        logic [DATA_W-1:0]  coef;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0] res_low;
        logic [DATA_W-1:0] res_high;
    } t_out;

    typedef struct packed {
        logic               is_signed;
        logic               use_mul;
        logic [WIDTH_W-1:0] n;
        logic [DATA_W-1:0]  mask;
        logic [DATA_W-1:0]  sign;
        logic [DATA_W-1:0]  small_low;
        logic [DATA_W-1:0]  small_high;
    } t_ctrl;

endpackage

/* rtl/bitvector_interval_add_mul.sv */
// top level: five-stage pipeline for wrapped interval add, subtract and add-multiply
`timescale 1ns / 1ps
// One item is taken in every cycle (busy never rises) and its result appears with
// o_done for a single cycle once it has passed the registers named below; results keep
// input order. The depth comes from the input register, the decode register, two stages
// of the split 65x65 multiply-add and the result register. The receiver cannot
// stall, so o_done and o_out must be captured in the cycle they are shown.
module bitvector_interval_add_mul
    import bvi_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_in,
    output logic busy,
    output logic o_done,
    output t_out o_out
);

    t_in                     r_in;
    t_ctrl                   n_ctrl, r_ctrl1, r_ctrl2, r_ctrl3;
    logic signed [EXT_W-1:0] n_a1, n_b1, n_a2, n_b2, n_c;
    logic signed [EXT_W-1:0] r_a1, r_b1, r_a2, r_b2, r_c;
    logic signed [PROD_W-1:0] v1, v2;
    t_out                    n_out, r_out;
    logic [3:0]              r_vld;
    logic                    r_done;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[2:0], start && !busy};
            r_done <= r_vld[3];
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= i_in;
    end

    bvi_decode #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_decode (
        .i_in   (r_in),
        .o_ctrl (n_ctrl),
        .o_a1   (n_a1),
        .o_b1   (n_b1),
        .o_a2   (n_a2),
        .o_b2   (n_b2),
        .o_c    (n_c)
    );

    always_ff @(posedge i_clk) begin
        r_ctrl1 <= n_ctrl;
        r_a1    <= n_a1;
        r_b1    <= n_b1;
        r_a2    <= n_a2;
        r_b2    <= n_b2;
        r_c     <= n_c;
        r_ctrl2 <= r_ctrl1;
        r_ctrl3 <= r_ctrl2;
    end

    bvi_mul u_mul_lo (
        .i_clk (i_clk),
        .i_a   (r_a1),
        .i_b   (r_b1),
        .i_c   (r_c),
        .o_v   (v1)
    );

    bvi_mul u_mul_hi (
        .i_clk (i_clk),
        .i_a   (r_a2),
        .i_b   (r_b2),
        .i_c   (r_c),
        .o_v   (v2)
    );

    bvi_resolve u_resolve (
        .i_ctrl (r_ctrl3),
        .i_v1   (v1),
        .i_v2   (v2),
        .o_out  (n_out)
    );

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_done = r_done;
    assign o_out  = r_out;

endmodule

/* rtl/bvi_decode.sv */
// operand masking, add/sub interval paths and operand pairing for add-multiply
`timescale 1ns / 1ps
module bvi_decode
    import bvi_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  t_in                      i_in,
    output t_ctrl                    o_ctrl,
    output logic signed [EXT_W-1:0]  o_a1,
    output logic signed [EXT_W-1:0]  o_b1,
    output logic signed [EXT_W-1:0]  o_a2,
    output logic signed [EXT_W-1:0]  o_b2,
    output logic signed [EXT_W-1:0]  o_c
);

    logic [WIDTH_W-1:0] n;
    logic [DATA_W-1:0]  m, sb, al, ah, l, u, c;
    logic [DATA_W-1:0]  sx, sy, dx, dy;
    logic [DATA_W-1:0]  addu_lo, addu_hi, adds_lo, adds_hi;
    logic [DATA_W-1:0]  subu_lo, subu_hi, subs_lo, subs_hi;
    logic               sgn, c_neg, c_one, c_all;
    logic               und_x, und_y, ovf_x, ovf_y;
    logic               dund_x, dund_y, dovf_x, dovf_y;

    function automatic logic neg(input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] s);
        return |(x & s);
    endfunction

    function automatic logic [EXT_W-1:0] ext(input logic [DATA_W-1:0] x,
                                             input logic [DATA_W-1:0] mk,
                                             input logic [DATA_W-1:0] s,
                                             input logic se);
        logic [EXT_W-1:0] r;
        if (se && |(x & s)) begin
            r = {1'b1, x | ~mk};
        end else begin
            r = {1'b0, x};
        end
        return r;
    endfunction

    always_comb begin
        if (i_in.width == '0) begin
            n = WIDTH_W'(1);
        end else if (i_in.width > WIDTH_W'(MAX_WIDTH)) begin
            n = WIDTH_W'(MAX_WIDTH);
        end else begin
            n = i_in.width;
        end
        // shift by the full width gives zero, so the mask becomes all ones
        m  = (DATA_W'(1) << n) - DATA_W'(1);
        sb = DATA_W'(1) << (n - WIDTH_W'(1));
        al = i_in.a_low  & m;
        ah = i_in.a_high & m;
        l  = i_in.b_low  & m;
        u  = i_in.b_high & m;
        c  = i_in.coef   & m;

        sx = (al + l) & m;
        sy = (ah + u) & m;
        dx = (al - u) & m;
        dy = (ah - l) & m;

        if (sy < u && sx >= l) begin
            addu_lo = '0;
            addu_hi = m;
        end else begin
            addu_lo = sx;
            addu_hi = sy;
        end

        und_x = neg(al, sb) && neg(l, sb) && !neg(sx, sb);
        und_y = neg(ah, sb) && neg(u, sb) && !neg(sy, sb);
        ovf_x = !neg(al, sb) && !neg(l, sb) && neg(sx, sb);
        ovf_y = !neg(ah, sb) && !neg(u, sb) && neg(sy, sb);
        if ((und_x && !und_y) || (ovf_y && !ovf_x)) begin
            adds_lo = sb;
            adds_hi = m >> 1;
        end else begin
            adds_lo = sx;
            adds_hi = sy;
        end

        if (al < u && ah >= l) begin
            subu_lo = '0;
            subu_hi = m;
        end else begin
            subu_lo = dx;
            subu_hi = dy;
        end

        dund_x = neg(al, sb) && !neg(u, sb) && !neg(dx, sb);
        dund_y = neg(ah, sb) && !neg(l, sb) && !neg(dy, sb);
        dovf_x = !neg(al, sb) && neg(u, sb) && neg(dx, sb);
        dovf_y = !neg(ah, sb) && neg(l, sb) && neg(dy, sb);
        if ((dund_x && !dund_y) || (dovf_y && !dovf_x)) begin
            subs_lo = sb;
            subs_hi = m >> 1;
        end else begin
            subs_lo = dx;
            subs_hi = dy;
        end

        sgn   = i_in.operation[0];
        c_neg = neg(c, sb);
        c_one = (c == DATA_W'(1));
        c_all = (c == m);

        o_ctrl.is_signed = sgn;
        o_ctrl.use_mul   = 1'b0;
        o_ctrl.n         = n;
        o_ctrl.mask      = m;
        o_ctrl.sign      = sb;
        case (i_in.operation)
            OP_ADD_U: begin
                o_ctrl.small_low  = addu_lo;
                o_ctrl.small_high = addu_hi;
            end
            OP_ADD_S: begin
                o_ctrl.small_low  = adds_lo;
                o_ctrl.small_high = adds_hi;
            end
            OP_SUB_U: begin
                o_ctrl.small_low  = subu_lo;
                o_ctrl.small_high = subu_hi;
            end
            OP_SUB_S: begin
                o_ctrl.small_low  = subs_lo;
                o_ctrl.small_high = subs_hi;
            end
            OP_ADDMUL_U, OP_ADDMUL_S: begin
                // unit coefficient first: at width one it is also all ones
                priority if (c_one) begin
                    o_ctrl.small_low  = sgn ? adds_lo : addu_lo;
                    o_ctrl.small_high = sgn ? adds_hi : addu_hi;
                end else if (c_all) begin
                    o_ctrl.small_low  = sgn ? subs_lo : subu_lo;
                    o_ctrl.small_high = sgn ? subs_hi : subu_hi;
                end else begin
                    o_ctrl.small_low  = '0;
                    o_ctrl.small_high = '0;
                    o_ctrl.use_mul    = 1'b1;
                end
            end
            default: begin
                o_ctrl.small_low  = '0;
                o_ctrl.small_high = '0;
            end
        endcase

        // coefficient is always taken signed: a negative one subtracts its magnitude
        o_c  = ext(c, m, sb, 1'b1);
        o_a1 = ext(al, m, sb, sgn);
        o_a2 = ext(ah, m, sb, sgn);
        o_b1 = ext(c_neg ? u : l, m, sb, sgn);
        o_b2 = ext(c_neg ? l : u, m, sb, sgn);
    end

endmodule

/* rtl/bvi_mul.sv */
// two-stage exact signed multiply-add v = a + b*c from products of 32- and 33-bit slices
`timescale 1ns / 1ps
module bvi_mul
    import bvi_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [EXT_W-1:0]  i_a,
    input  logic signed [EXT_W-1:0]  i_b,
    input  logic signed [EXT_W-1:0]  i_c,
    output logic signed [PROD_W-1:0] o_v
);

    localparam int LO_W = 32;
    localparam int HI_W = EXT_W - LO_W;
    localparam int PP_W = 2 * (HI_W + 1);

    logic        [2*LO_W-1:0] n_ll, r_ll;
    logic signed [PP_W-1:0]   n_lh, r_lh, n_hl, r_hl, n_hh, r_hh;
    logic signed [EXT_W-1:0]  r_a;
    logic signed [PROD_W-1:0] n_v, r_v;
    logic signed [PROD_W-1:0] mid_sum;

    always_comb begin
        n_ll = i_b[LO_W-1:0] * i_c[LO_W-1:0];
        n_lh = $signed({1'b0, i_b[LO_W-1:0]}) * $signed(i_c[EXT_W-1:LO_W]);
        n_hl = $signed(i_b[EXT_W-1:LO_W]) * $signed({1'b0, i_c[LO_W-1:0]});
        n_hh = $signed(i_b[EXT_W-1:LO_W]) * $signed(i_c[EXT_W-1:LO_W]);
    end

    always_ff @(posedge i_clk) begin
        r_ll <= n_ll;
        r_lh <= n_lh;
        r_hl <= n_hl;
        r_hh <= n_hh;
        r_a  <= i_a;
    end

    always_comb begin
        mid_sum = PROD_W'(r_lh) + PROD_W'(r_hl);
        n_v     = (PROD_W'(r_hh) <<< (2 * LO_W)) + (mid_sum <<< LO_W)
                + $signed({{(PROD_W - 2*LO_W){1'b0}}, r_ll}) + PROD_W'(r_a);
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
    end

    assign o_v = r_v;

endmodule

/* rtl/bvi_resolve.sv */
// wrap detection from the floor quotients and final interval selection
`timescale 1ns / 1ps
module bvi_resolve
    import bvi_pkg::*;
(
    input  t_ctrl                    i_ctrl,
    input  logic signed [PROD_W-1:0] i_v1,
    input  logic signed [PROD_W-1:0] i_v2,
    output t_out                     o_out
);

    logic signed [PROD_W-1:0] q1, q2, q1p;
    logic [DATA_W-1:0]        x, y;
    logic                     same_q, next_q, le, keep;

    always_comb begin
        x      = i_v1[DATA_W-1:0] & i_ctrl.mask;
        y      = i_v2[DATA_W-1:0] & i_ctrl.mask;
        q1     = i_v1 >>> i_ctrl.n;
        q2     = i_v2 >>> i_ctrl.n;
        q1p    = q1 + PROD_W'(1);
        same_q = (q1 == q2);
        next_q = (q1p == q2);
        le     = (x ^ i_ctrl.sign) <= (y ^ i_ctrl.sign);
        // signed: ends may straddle the boundary only from negative into positive
        keep   = (same_q && le) || (next_q && |(x & i_ctrl.sign) && !(|(y & i_ctrl.sign)));

        if (!i_ctrl.use_mul) begin
            o_out.res_low  = i_ctrl.small_low;
            o_out.res_high = i_ctrl.small_high;
        end else if (!i_ctrl.is_signed) begin
            o_out.res_low  = same_q ? x : '0;
            o_out.res_high = same_q ? y : i_ctrl.mask;
        end else begin
            o_out.res_low  = keep ? x : i_ctrl.sign;
            o_out.res_high = keep ? y : (i_ctrl.mask >> 1);
        end
    end

endmodule

/* rtl/bvi_checker.sv */
// port-level checks for the interval block and their bind to the top level
`timescale 1ns / 1ps
module bvi_checker
    import bvi_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input t_in  i_in,
    input logic busy,
    input logic o_done,
    input t_out o_out
);

    // every transfer yields exactly one result
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_done)
        else $error("missing result after transfer");

    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 5))
        else $error("result without transfer");

    // unused operation codes give an empty pattern
    a_unused_op_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_in.operation[2] && i_in.operation[1])
        |-> ##5 (o_out.res_low == '0 && o_out.res_high == '0))
        else $error("unused operation gave nonzero result");

    // width one leaves only bit zero
    a_width_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_in.width == WIDTH_W'(1))
        |-> ##5 (o_out.res_low[DATA_W-1:1] == '0 && o_out.res_high[DATA_W-1:1] == '0))
        else $error("bits above width one are set");

endmodule

bind bitvector_interval_add_mul bvi_checker u_bvi_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_in    (i_in),
    .busy    (busy),
    .o_done  (o_done),
    .o_out   (o_out)
);
